// ===== hw/rtl/gmw_pkg.sv =====
// gmw_pkg: shared types, constants and helpers for the 3x3 gray morphology core.
// Used by the stream interfaces, gmw_stage and gray_morphology_window_3x3_core.
`default_nettype none

package gmw_pkg;

  localparam int PIX_W         = 8;
  localparam int OPC_W         = 1;
  localparam int IMG_W_W       = 11;
  localparam int ROW_W         = 16;
  localparam int MODE_W        = 2;
  localparam int DEF_MAX_WIDTH = 1024;

  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [IMG_W_W-1:0] RST_IMG_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0]   RST_IMG_HEIGHT = 16'd480;

  // row banks of a stage's line store, and rows in the window
  localparam int BANKS  = 4;
  localparam int BANK_W = 2;
  localparam int WIN    = 3;

  // output queue
  localparam int OUT_DEPTH = 8;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // APB
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [OPC_W-1:0] OP_PIXEL = 1'b0;
  localparam logic [OPC_W-1:0] OP_FLUSH = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_CLOSE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic             step;
    logic             has_pix;
    logic [PIX_W-1:0] pix;
  } stg_in_t;

  typedef struct packed {
    logic             step;
    logic             got;
    logic             last;
    logic [PIX_W-1:0] pix;
  } stg_out_t;

  function automatic logic [PIX_W-1:0] pick(input logic take_max,
                                            input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    if (take_max) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gmw_if.sv =====
// gmw_if: valid/ready stream interfaces for pixel words in and filtered words out.
// Depends on gmw_pkg for payload widths.
`default_nettype none

interface gmw_in_if
  import gmw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface gmw_out_if
  import gmw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gmw_stage.sv =====
// gmw_stage: one clipped 3x3 min/max window stage over four row-banked line stores.
// A read stage and an output register lie between step and result. Depends on gmw_pkg.
`default_nettype none

module gmw_stage
  import gmw_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic                           take_max,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
  input  logic [ROW_W-1:0]               height,
  input  stg_in_t                        sin,
  output stg_out_t                       sout
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_WIDTH + 3);

  // position counters
  logic [AW-1:0]     ic, ic_acc, oc, oc_next;
  logic [ROW_W-1:0]  ir, ir_acc, orow, orow_next;
  logic [BANK_W-1:0] ib, ib_acc, ob, ob_next;
  logic [PW-1:0]     pend, pend_acc, pend_next;
  logic              behind, behind_acc, behind_next;

  logic [WW-1:0]     ic_inc, oc_inc;
  logic [ROW_W:0]    ir_inc, orow_inc;
  logic [ROW_W-1:0]  need_row;
  logic [AW-1:0]     need_col;
  logic              wr_en, emit, top_ok, bot_ok, lft_ok, rgt_ok;

  assign wr_en    = sin.step && sin.has_pix;
  assign ic_inc   = WW'(ic) + WW'(1);
  assign oc_inc   = WW'(oc) + WW'(1);
  assign ir_inc   = {1'b0, ir} + (ROW_W+1)'(1);
  assign orow_inc = {1'b0, orow} + (ROW_W+1)'(1);
  assign top_ok   = orow != '0;
  assign bot_ok   = orow_inc < {1'b0, height};
  assign lft_ok   = oc != '0;
  assign rgt_ok   = oc_inc < width;
  assign need_row = bot_ok ? orow_inc[ROW_W-1:0] : height - ROW_W'(1);
  assign need_col = rgt_ok ? AW'(oc_inc) : AW'(width - WW'(1));

  always_comb begin
    ic_acc     = ic;
    ir_acc     = ir;
    ib_acc     = ib;
    pend_acc   = pend;
    behind_acc = behind;
    if (wr_en) begin
      pend_acc = pend + PW'(1);
      if (ic_inc >= width) begin
        ic_acc = '0;
        ib_acc = ib + BANK_W'(1);
        if (ir_inc >= {1'b0, height}) begin
          ir_acc     = '0;
          behind_acc = 1'b1;
        end else begin
          ir_acc = ir_inc[ROW_W-1:0];
        end
      end else begin
        ic_acc = AW'(ic_inc);
      end
    end
  end

  // output (r,c) may leave once pixel (min(r+1,h-1), min(c+1,w-1)) is in
  assign emit = sin.step && (pend_acc != '0) &&
                (behind_acc || (ir_acc > need_row) ||
                 ((ir_acc == need_row) && (ic_acc > need_col)));

  always_comb begin
    oc_next     = oc;
    orow_next   = orow;
    ob_next     = ob;
    pend_next   = pend_acc;
    behind_next = behind_acc;
    if (emit) begin
      pend_next = pend_acc - PW'(1);
      if (rgt_ok) begin
        oc_next = AW'(oc_inc);
      end else begin
        oc_next = '0;
        ob_next = ob + BANK_W'(1);
        if (bot_ok) begin
          orow_next = orow_inc[ROW_W-1:0];
        end else begin
          orow_next   = '0;
          behind_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ic     <= '0;
      ir     <= '0;
      ib     <= '0;
      oc     <= '0;
      orow   <= '0;
      ob     <= '0;
      pend   <= '0;
      behind <= 1'b0;
    end else begin
      ic     <= ic_acc;
      ir     <= ir_acc;
      ib     <= ib_acc;
      oc     <= oc_next;
      orow   <= orow_next;
      ob     <= ob_next;
      pend   <= pend_next;
      behind <= behind_next;
    end
  end

  // line store: row k of the stream lives in bank k mod 4, addressed by column
  logic [AW-1:0]    ra0, ra1;
  logic [PIX_W-1:0] rd0 [BANKS];
  logic [PIX_W-1:0] rd1 [BANKS];

  assign ra0 = oc;
  assign ra1 = AW'(oc_inc);

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (wr_en && (ib == BANK_W'(b))) begin
        mem[ic] <= sin.pix;
      end
      rd0[b] <= mem[ra0];
      rd1[b] <= mem[ra1];
    end
  end

  // read stage
  logic              step_q, emit_q, we_q;
  logic [BANK_W-1:0] ob_q, wb_q;
  logic [AW-1:0]     ra0_q, ra1_q, wa_q;
  logic [PIX_W-1:0]  wd_q;
  logic              top_q, bot_q, lft_q, rgt_q, last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q <= 1'b0;
      emit_q <= 1'b0;
      we_q   <= 1'b0;
    end else begin
      step_q <= sin.step;
      emit_q <= emit;
      we_q   <= wr_en;
    end
    ob_q   <= ob;
    wb_q   <= ib;
    wa_q   <= ic;
    wd_q   <= sin.pix;
    ra0_q  <= ra0;
    ra1_q  <= ra1;
    top_q  <= top_ok;
    bot_q  <= bot_ok;
    lft_q  <= lft_ok;
    rgt_q  <= rgt_ok;
    last_q <= !bot_ok && !rgt_ok;
  end

  logic [BANK_W-1:0] rbank [WIN];
  logic [PIX_W-1:0]  cen   [WIN];
  logic [PIX_W-1:0]  rgt   [WIN];
  logic [PIX_W-1:0]  lcol  [WIN];
  logic [PIX_W-1:0]  rowv  [WIN];
  logic [PIX_W-1:0]  ident, res;

  assign ident = take_max ? PIX_MIN : PIX_MAX;

  // same-cycle write is forwarded over the read-first data
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      rbank[k] = ob_q + BANK_W'(k) - BANK_W'(1);
      cen[k]   = (we_q && (wb_q == rbank[k]) && (wa_q == ra0_q)) ? wd_q : rd0[rbank[k]];
      rgt[k]   = (we_q && (wb_q == rbank[k]) && (wa_q == ra1_q)) ? wd_q : rd1[rbank[k]];
      rowv[k]  = pick(take_max, pick(take_max, cen[k], lft_q ? lcol[k] : ident),
                      rgt_q ? rgt[k] : ident);
    end
    res = pick(take_max, pick(take_max, top_q ? rowv[0] : ident, rowv[1]),
               bot_q ? rowv[2] : ident);
  end

  always_ff @(posedge clk) begin
    if (emit_q) begin
      for (int k = 0; k < WIN; k++) begin
        lcol[k] <= cen[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sout.step <= 1'b0;
      sout.got  <= 1'b0;
    end else begin
      sout.step <= step_q;
      sout.got  <= emit_q;
    end
    sout.pix  <= res;
    sout.last <= last_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gray_morphology_window_3x3_core.sv =====
// gray_morphology_window_3x3_core: top level, APB registers, two cascaded stages, output queue.
// Depends on gmw_pkg, gmw_if (gmw_in_if, gmw_out_if) and gmw_stage.
//
// Usage:
//   din carries raster-order words: opcode pixel with an 8-bit gray value, or opcode
//   flush, which carries no pixel and only lets a pending result leave. dout carries
//   the filtered pixels in raster order, frame_end marking the last pixel of a frame.
//   Each word accepted on din yields zero or one word on dout.
//   Throughput: one word per cycle; din.ready stays high while the downstream keeps up.
//   Latency: a stage holds results back by image_width+1 words of the stream (two stages
//   for open/close). Each result passes the registered line-store read and the window
//   compare of each stage, then the output queue.
//   When dout is stalled, results queue in an 8-word buffer; din.ready drops once that
//   buffer plus words still in the pipeline would fill it.
//   Reset clears all counters and the queue; registers return to 640x480, erode.
//   Line stores are not cleared. Any register write restarts both stages at the top of
//   a frame and drops pending results; write registers only while the block is idle.
`default_nettype none

module gray_morphology_window_3x3_core
  import gmw_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  gmw_in_if.sink            din,
  gmw_out_if.source         dout,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  // registers
  logic [IMG_W_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  mode_t              filter_mode;
  logic               cfg_wr, restart;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && (paddr[3:2] inside {REG_WIDTH, REG_HEIGHT, REG_MODE});

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMG_WIDTH;
      image_height <= RST_IMG_HEIGHT;
      filter_mode  <= MODE_ERODE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[IMG_W_W-1:0];
        REG_HEIGHT: image_height <= pwdata[ROW_W-1:0];
        REG_MODE:   filter_mode  <= mode_t'(pwdata[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = APB_DW'(image_width);
      REG_HEIGHT: prdata = APB_DW'(image_height);
      REG_MODE:   prdata = APB_DW'(filter_mode);
      default:    prdata = '0;
    endcase
  end

  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             first_max, two_stage;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
  end

  assign eff_h     = (image_height == '0) ? ROW_W'(1) : image_height;
  assign first_max = filter_mode inside {MODE_DILATE, MODE_CLOSE};
  assign two_stage = filter_mode inside {MODE_OPEN, MODE_CLOSE};

  // stages
  logic     acc;
  stg_in_t  a_in, b_in;
  stg_out_t a_out, b_out, fin;
  logic [CNT_W-1:0] busy, fcnt;

  assign din.ready = !rst && (busy < CNT_W'(OUT_DEPTH));
  assign acc       = din.valid && din.ready;
  assign a_in      = '{step: acc, has_pix: (din.opcode == OP_PIXEL), pix: din.pixel_in};
  assign b_in      = '{step: a_out.step, has_pix: a_out.got, pix: a_out.pix};

  gmw_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_stage_a (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .take_max (first_max),
    .width    (eff_w),
    .height   (eff_h),
    .sin      (a_in),
    .sout     (a_out)
  );

  gmw_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_stage_b (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .take_max (!first_max),
    .width    (eff_w),
    .height   (eff_h),
    .sin      (b_in),
    .sout     (b_out)
  );

  assign fin = two_stage ? b_out : a_out;

  // output queue; busy counts queued words plus steps still in the pipeline
  logic [PIX_W-1:0] fifo_pix  [OUT_DEPTH];
  logic             fifo_last [OUT_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic             push, pop, noemit;

  assign push   = fin.step && fin.got;
  assign noemit = fin.step && !fin.got;
  assign pop    = dout.valid && dout.ready;

  assign dout.valid     = fcnt != '0;
  assign dout.pixel_out = fifo_pix[rptr];
  assign dout.frame_end = fifo_last[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fcnt <= '0;
      busy <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      fcnt <= fcnt + CNT_W'(push) - CNT_W'(pop);
      busy <= busy + CNT_W'(acc) - CNT_W'(noemit) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_pix[wptr]  <= fin.pix;
      fifo_last[wptr] <= fin.last;
    end
  end

`ifndef SYNTHESIS
  a_queue_covered: assert property (@(posedge clk) disable iff (rst) fcnt <= busy)
    else $error("output queue holds more words than steps in flight");

  a_stage_a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##2 a_out.step)
    else $error("first stage lost a step");

  a_stage_b_latency: assert property (@(posedge clk) disable iff (rst)
    a_out.step |-> ##2 b_out.step)
    else $error("second stage lost a step");

  a_got_has_step: assert property (@(posedge clk) disable iff (rst)
    (!a_out.got || a_out.step) && (!b_out.got || b_out.step))
    else $error("stage result without a step");
`endif

endmodule

`default_nettype wire

// ===== dv/gray_morphology_window_3x3_core_tb.sv =====
// Self-checking testbench for gray_morphology_window_3x3_core: random and directed frames
// in all four modes, with a cycle-accurate-free predictor held in a scoreboard class.
// Depends on gmw_pkg, gmw_in_if / gmw_out_if and the core RTL.
module gray_morphology_window_3x3_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gmw_pkg::*;

  localparam int HIST_LEN    = 2 * DEF_MAX_WIDTH + 4;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    int unsigned wr_ptr;
    int unsigned pending;
    int unsigned in_row;
    int unsigned in_col;
    int unsigned out_row;
    int unsigned out_col;
    bit          behind;
  } scan_pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             frame_end;
  } filt_word_t;

  function automatic int unsigned clip_width(int unsigned w);
    if (w == 0) return 1;
    if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned clip_height(int unsigned h);
    return (h == 0) ? 1 : h;
  endfunction

  class morph_scoreboard;
    logic [PIX_W-1:0] history [2][HIST_LEN];
    scan_pos_t        scan [2];
    int unsigned      width_cfg;
    int unsigned      height_cfg;
    mode_t            mode_cfg;
    filt_word_t       expected_q [$];
    int               errors;

    function new();
      foreach (history[s, i]) history[s][i] = '0;
      restart_stages();
      width_cfg  = RST_IMG_WIDTH;
      height_cfg = RST_IMG_HEIGHT;
      mode_cfg   = MODE_ERODE;
      errors     = 0;
    endfunction

    function void restart_stages();
      foreach (scan[s]) scan[s] = '{default: 0};
    endfunction

    function void write_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
      case (idx)
        REG_WIDTH:  width_cfg = val[IMG_W_W-1:0];
        REG_HEIGHT: height_cfg = val[ROW_W-1:0];
        REG_MODE:   mode_cfg = mode_t'(val[MODE_W-1:0]);
        default:    return;
      endcase
      restart_stages();
    endfunction

    function void push_pixel(int s, logic [PIX_W-1:0] v, int unsigned w, int unsigned h);
      history[s][scan[s].wr_ptr] = v;
      scan[s].wr_ptr = (scan[s].wr_ptr + 1) % HIST_LEN;
      scan[s].pending++;
      scan[s].in_col++;
      if (scan[s].in_col >= w) begin
        scan[s].in_col = 0;
        scan[s].in_row++;
        if (scan[s].in_row >= h) begin
          scan[s].in_row = 0;
          scan[s].behind = 1'b1;
        end
      end
    endfunction

    // next output of a stage once its whole clipped neighborhood has arrived
    function bit pop_window(int s, bit take_max, int unsigned w, int unsigned h,
                            output logic [PIX_W-1:0] v, output bit last);
      int unsigned      center, rl, cl;
      int               rr, cc, idx;
      logic [PIX_W-1:0] acc, px;
      if (scan[s].pending == 0 || scan[s].pending >= HIST_LEN) return 0;
      if (!scan[s].behind) begin
        rl = (scan[s].out_row + 1 < h) ? scan[s].out_row + 1 : h - 1;
        cl = (scan[s].out_col + 1 < w) ? scan[s].out_col + 1 : w - 1;
        if (scan[s].in_row * w + scan[s].in_col <= rl * w + cl) return 0;
      end
      center = (scan[s].wr_ptr + HIST_LEN - scan[s].pending) % HIST_LEN;
      acc = take_max ? PIX_MIN : PIX_MAX;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = int'(scan[s].out_row) + dr;
          cc = int'(scan[s].out_col) + dc;
          if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
          idx = (int'(center) + HIST_LEN + dr * int'(w) + dc) % HIST_LEN;
          px = history[s][idx];
          if (take_max ? (px > acc) : (px < acc)) acc = px;
        end
      end
      v = acc;
      last = (scan[s].out_row == h - 1 && scan[s].out_col == w - 1);
      scan[s].pending--;
      scan[s].out_col++;
      if (scan[s].out_col >= w) begin
        scan[s].out_col = 0;
        scan[s].out_row++;
        if (scan[s].out_row >= h) begin
          scan[s].out_row = 0;
          scan[s].behind = 1'b0;
        end
      end
      return 1;
    endfunction

    function void note_word(logic [OPC_W-1:0] op, logic [PIX_W-1:0] pix);
      int unsigned      w, h;
      bit               first_max, cascade, got, last;
      logic [PIX_W-1:0] v;
      filt_word_t       nw;
      w = clip_width(width_cfg);
      h = clip_height(height_cfg);
      first_max = (mode_cfg == MODE_DILATE || mode_cfg == MODE_CLOSE);
      cascade = (mode_cfg == MODE_OPEN || mode_cfg == MODE_CLOSE);
      last = 1'b0;
      v = '0;
      if (op == OP_PIXEL) push_pixel(0, pix, w, h);
      got = pop_window(0, first_max, w, h, v, last);
      if (cascade) begin
        if (got) push_pixel(1, v, w, h);
        got = pop_window(1, !first_max, w, h, v, last);
      end
      if (got) begin
        nw.pix = v;
        nw.frame_end = last;
        expected_q.insert(expected_q.size(), nw);
      end
    endfunction

    function void check_word(logic [PIX_W-1:0] pix, logic frame_end);
      filt_word_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word pixel_out %0d frame_end %0b", $time, pix, frame_end);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (pix !== exp_w.pix) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, exp_w.pix, pix);
        errors++;
      end
      if (frame_end !== exp_w.frame_end) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, exp_w.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic              pready;

  gmw_in_if  din_if ();
  gmw_out_if dout_if ();

  gray_morphology_window_3x3_core u_top (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  morph_scoreboard sb = new();
  int          cycles = 0;
  int          burst_left = 0;
  int unsigned pixel_words = 0;
  int          rx_style = 0;
  int          rx_left = 0;
  int          rx_hold = 0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (!rst && dout_if.valid && dout_if.ready) begin
      sb.check_word(dout_if.pixel_out, dout_if.frame_end);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_style)
      0: dout_if.ready <= 1'b1;
      1: dout_if.ready <= 1'($urandom_range(0, 1));
      2: dout_if.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          dout_if.ready <= 1'b0;
        end else begin
          dout_if.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 20);
        end
      end
    endcase
  end

  task automatic idle_input(int n);
    @(negedge clk) din_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(logic [OPC_W-1:0] op, logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_input(gap);
    end
    burst_left--;
    @(negedge clk);
    din_if.valid <= 1'b1;
    din_if.opcode <= op;
    din_if.pixel_in <= pix;
    do @(posedge clk); while (!din_if.ready);
    sb.note_word(op, pix);
    if (op == OP_PIXEL) pixel_words++;
  endtask

  task automatic apb_access(logic [1:0] idx, logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] mask;
    case (idx)
      REG_WIDTH:  mask = (1 << IMG_W_W) - 1;
      REG_HEIGHT: mask = (1 << ROW_W) - 1;
      default:    mask = (1 << MODE_W) - 1;
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= data;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (data & mask)) begin
      $display("%0t: register %0d readback expected %0d actual %0d",
               $time, idx, data & mask, prdata & mask);
      sb.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(int unsigned w, int unsigned h, mode_t mode);
    idle_input(1);
    wait_drain();
    repeat (SETTLE) @(negedge clk);
    apb_access(REG_WIDTH, w);
    apb_access(REG_HEIGHT, h);
    apb_access(REG_MODE, APB_DW'(mode));
  endtask

  task automatic send_frame(int npix, bit extremes, bit noise, int pause_at);
    for (int i = 0; i < npix; i++) begin
      if (i == pause_at) begin
        idle_input(1);
        wait_drain();
      end
      if (noise && $urandom_range(0, 15) == 0) send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
      send_word(OP_PIXEL, extremes ? ($urandom_range(0, 1) ? PIX_MAX : PIX_MIN)
                                   : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, mode_t mode, int nframes,
                           int tail, bit extremes, bit noise, bit pause);
    int unsigned ew, eh, flushes;
    ew = clip_width(w);
    eh = clip_height(h);
    configure(w, h, mode);
    // nothing can be ready yet
    send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
    for (int f = 0; f < nframes; f++) begin
      send_frame(ew * eh, extremes, noise, (pause && f == 0) ? int'(ew * eh / 2) : -1);
      if (noise && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
      end
    end
    // partial frame: its pending words are dropped by the next register write
    if (tail > 0) send_frame(tail, extremes, noise, -1);
    if (nframes == 0) begin
      // no frame completes, so flushes release nothing
      flushes = 2;
    end else begin
      flushes = (mode == MODE_OPEN || mode == MODE_CLOSE) ? 2 * ew + 2 : ew + 1;
    end
    if (noise) flushes += $urandom_range(0, 3);
    repeat (flushes) send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase();
    int unsigned w, h, area;
    int          tail;
    case ($urandom_range(0, 19))
      0:          w = $urandom_range(41, 120);
      1, 2, 3, 4: w = $urandom_range(9, 40);
      default:    w = $urandom_range(1, 8);
    endcase
    h = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    area = w * h;
    tail = (area > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, area - 1) : 0;
    run_phase(w, h, mode_t'($urandom_range(0, 3)), $urandom_range(1, 3), tail,
              $urandom_range(0, 4) == 0, 1'b1, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    int unsigned goal;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    din_if.valid = 1'b0;
    din_if.opcode = OP_PIXEL;
    din_if.pixel_in = '0;
    dout_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    run_phase(3, 2, MODE_ERODE, 1, 0, 1'b1, 1'b0, 1'b0);
    run_phase(2, 1, MODE_DILATE, 1, 0, 1'b1, 1'b0, 1'b0);
    run_phase(1, 2, MODE_OPEN, 1, 0, 1'b1, 1'b0, 1'b0);
    run_phase(2, 2, MODE_CLOSE, 1, 0, 1'b1, 1'b0, 1'b1);

    // register extremes: zero size, oversize width, tallest frame
    run_phase(0, 0, MODE_OPEN, 3, 0, 1'b0, 1'b1, 1'b0);
    run_phase(2047, 2, MODE_ERODE, 0, 40, 1'b0, 1'b1, 1'b0);
    run_phase(1024, 1, MODE_CLOSE, 0, 24, 1'b1, 1'b0, 1'b0);
    run_phase(1, 65535, MODE_DILATE, 0, 60, 1'b0, 1'b1, 1'b0);

    goal = pixel_words + 550;
    while (pixel_words < goal) random_phase();

    idle_input(1);
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
